FILE: hw/rtl/osq_pkg.sv
// Package for the ordered sequence store: sizes, codes, beat and control types.
package osq_pkg;

  localparam int DEPTH = 64;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  // operation codes
  localparam logic [2:0] MODE_INS_BEFORE = 3'd0;
  localparam logic [2:0] MODE_INS_AFTER  = 3'd1;
  localparam logic [2:0] MODE_DEL_AT     = 3'd2;
  localparam logic [2:0] MODE_DEL_LAST   = 3'd3;
  localparam logic [2:0] MODE_INS_SORTED = 3'd4;
  localparam logic [2:0] MODE_READ       = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]           mode;
    logic signed [DW-1:0] value;
    logic [5:0]           position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [6:0]           count;
    logic signed [DW-1:0] read_value;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 cmp_en;  // capture compare flags against value
    logic                 ins_en;  // apply an insert
    logic                 del_en;  // apply a delete
    logic                 use_ge;  // insert point from compare flags
    logic [IDXW-1:0]      k;       // insert or delete index
    logic [IDXW-1:0]      rpos;    // read index
    logic [IDXW-1:0]      last;    // index of last element
    logic signed [DW-1:0] value;
  } ctl_t;

endpackage

FILE: hw/rtl/ordered_sequence_store_top.sv
// Top level of the ordered sequence store: command control and the cell chain.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_data  (mode, value, position)
//  out_    | out | out_valid/out_stall| out_data (status, count, read_value)
//
// Each beat passes three steps: capture, compare (every cell registers its
// less-than / greater-than flags against the value), then apply, where insert
// point, shift and read ripple combinationally along the cell chain.
// Apply waits while a finished result is stalled in the output register; the
// next beat is taken as soon as apply has gone.
// Reset clears the count and the control state; cell contents are left as they
// are and never read below the count before being written.
module ordered_sequence_store_top import osq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        cmd_r;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            out_valid_r;
  out_item_t       out_data_r, out_data_nxt;

  ctl_t            ctl;
  logic            out_free, apply_go;
  logic            n_zero, n_full, pos_bad, mid;
  logic [1:0]      status;
  logic [DW-1:0]   rd_val;

  // chain wiring
  logic signed [DW-1:0] elem_w [DEPTH];
  logic [DEPTH-1:0]     lt_w;
  logic [DEPTH:0]       after_c;
  logic [DEPTH:0]       gl_c;
  logic [DW-1:0]        rd_c [DEPTH+1];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign apply_go  = (state_r == S_APPLY) && out_free;

  assign n_zero  = (count_r == '0);
  assign n_full  = (count_r == CNTW'(DEPTH));
  assign pos_bad = 32'(cmd_r.position) >= 32'(count_r);
  // sorted insert falls strictly between first and last element
  assign mid     = lt_w[0] & gl_c[DEPTH];

  always_comb begin
    status       = ST_OK;
    count_nxt    = count_r;
    rd_val       = '0;
    ctl          = '0;
    ctl.cmp_en   = (state_r == S_CMP);
    ctl.value    = cmd_r.value;
    ctl.rpos     = IDXW'(cmd_r.position);
    ctl.last     = IDXW'(32'(count_r) - 32'd1);
    case (cmd_r.mode)
      MODE_INS_BEFORE, MODE_INS_AFTER: begin
        if (n_full) begin
          status = ST_FULL;
        end else if (n_zero) begin
          ctl.ins_en = apply_go;
          count_nxt  = count_r + 1'b1;
        end else if (pos_bad) begin
          status = ST_RANGE;
        end else begin
          ctl.ins_en = apply_go;
          ctl.k      = (cmd_r.mode == MODE_INS_BEFORE) ? IDXW'(cmd_r.position) :
                       IDXW'(32'(cmd_r.position) + 32'd1);
          count_nxt  = count_r + 1'b1;
        end
      end
      MODE_DEL_AT: begin
        if (n_zero) begin
          status = ST_EMPTY;
        end else if (pos_bad) begin
          status = ST_RANGE;
        end else begin
          ctl.del_en = apply_go;
          ctl.k      = IDXW'(cmd_r.position);
          count_nxt  = count_r - 1'b1;
        end
      end
      MODE_DEL_LAST: begin
        if (n_zero) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      MODE_INS_SORTED: begin
        if (n_full) begin
          status = ST_FULL;
        end else begin
          ctl.ins_en = apply_go;
          count_nxt  = count_r + 1'b1;
          if (n_zero) begin
            ctl.k = '0;
          end else if (mid) begin
            ctl.use_ge = 1'b1;
          end else if (!lt_w[0]) begin
            ctl.k = '0;            // at or below the head
          end else begin
            ctl.k = IDXW'(count_r); // append
          end
        end
      end
      MODE_READ: begin
        if (n_zero) begin
          status = ST_EMPTY;
        end else if (pos_bad) begin
          status = ST_RANGE;
        end else begin
          rd_val = rd_c[DEPTH];
        end
      end
      default: begin
      end
    endcase
    out_data_nxt.status     = status;
    out_data_nxt.count      = 7'(count_nxt);
    out_data_nxt.read_value = rd_val;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      cmd_r <= in_data;
    end
    if (apply_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  // cell chain
  assign after_c[0] = 1'b0;
  assign gl_c[0]    = 1'b0;
  assign rd_c[0]    = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = elem_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = elem_w[g+1];
    end

    osq_cell u_cell (
      .clk        (clk),
      .idx        (IDXW'(g)),
      .ctl        (ctl),
      .left_elem  (left_w),
      .right_elem (right_w),
      .after_in   (after_c[g]),
      .after_out  (after_c[g+1]),
      .rd_in      (rd_c[g]),
      .rd_out     (rd_c[g+1]),
      .gl_in      (gl_c[g]),
      .gl_out     (gl_c[g+1]),
      .elem       (elem_w[g]),
      .lt_flag    (lt_w[g])
    );
  end

endmodule

FILE: hw/rtl/osq_cell.sv
// One cell of the sequence chain: holds one element and shifts with its neighbours.
module osq_cell import osq_pkg::*; (
  input  logic                 clk,
  input  logic [IDXW-1:0]      idx,
  input  ctl_t                 ctl,
  input  logic signed [DW-1:0] left_elem,
  input  logic signed [DW-1:0] right_elem,
  input  logic                 after_in,
  output logic                 after_out,
  input  logic [DW-1:0]        rd_in,
  output logic [DW-1:0]        rd_out,
  input  logic                 gl_in,
  output logic                 gl_out,
  output logic signed [DW-1:0] elem,
  output logic                 lt_flag
);

  logic signed [DW-1:0] elem_r, elem_nxt;
  logic                 lt_r, gt_r;
  logic                 hit;

  // insert point: first cell not below value, or the addressed cell
  assign hit       = ctl.use_ge ? ~lt_r : (idx == ctl.k);
  assign after_out = after_in | hit;
  assign rd_out    = rd_in | ((idx == ctl.rpos) ? elem_r : '0);
  assign gl_out    = gl_in | ((idx == ctl.last) & gt_r);
  assign elem      = elem_r;
  assign lt_flag   = lt_r;

  always_comb begin
    elem_nxt = elem_r;
    if (ctl.ins_en) begin
      if (after_in) begin
        elem_nxt = left_elem;
      end else if (hit) begin
        elem_nxt = ctl.value;
      end
    end else if (ctl.del_en && (idx >= ctl.k)) begin
      elem_nxt = right_elem;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    if (ctl.cmp_en) begin
      lt_r <= elem_r < ctl.value;
      gt_r <= elem_r > ctl.value;
    end
  end

endmodule

FILE: hw/rtl/osq_checker.sv
// Port checker for the ordered sequence store, bound to the top level.
module osq_checker import osq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a beat is in work");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (32'(out_data.count) == DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> (out_data.count == '0))
    else $error("empty status with non-zero count");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.read_value == '0))
    else $error("read value not zero on failed beat");

endmodule

bind ordered_sequence_store_top osq_checker u_osq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tb_ordered_sequence_store_top.sv
// Self-checking testbench for the ordered sequence store: random traffic, scoreboard, stalls.
`timescale 1ns / 1ps

import osq_pkg::*;

// Shadow copy of the sequence. next_reply() advances it by one beat and
// returns the reply the block owes for that beat.
class seq_store_scoreboard;
  logic signed [DW-1:0] elems [DEPTH];
  int                   fill;
  out_item_t            replies_due [$];
  int                   faults;

  function new();
    fill   = 0;
    faults = 0;
  endfunction

  function void place(int idx, logic signed [DW-1:0] v);
    for (int i = fill; i > idx; i--) elems[i] = elems[i-1];
    elems[idx] = v;
    fill++;
  endfunction

  function void remove(int idx);
    for (int i = idx; i + 1 < fill; i++) elems[i] = elems[i+1];
    fill--;
  endfunction

  function out_item_t next_reply(in_item_t op);
    out_item_t rep;
    int        n;
    int        pos;
    int        slot;
    rep = '0;
    rep.status = ST_OK;
    n = fill;
    pos = int'(op.position);
    case (op.mode)
      MODE_INS_BEFORE, MODE_INS_AFTER: begin
        if (n >= DEPTH) rep.status = ST_FULL;
        else if (n == 0) place(0, op.value);
        else if (pos >= n) rep.status = ST_RANGE;
        else place((op.mode == MODE_INS_BEFORE) ? pos : pos + 1, op.value);
      end
      MODE_DEL_AT: begin
        if (n == 0) rep.status = ST_EMPTY;
        else if (pos >= n) rep.status = ST_RANGE;
        else remove(pos);
      end
      MODE_DEL_LAST: begin
        if (n == 0) rep.status = ST_EMPTY;
        else fill--;
      end
      MODE_INS_SORTED: begin
        if (n >= DEPTH) begin
          rep.status = ST_FULL;
        end else if (n == 0) begin
          place(0, op.value);
        end else if (elems[0] < op.value && op.value < elems[n-1]) begin
          slot = 0;
          while (slot < n && elems[slot] < op.value) slot++;
          place(slot, op.value);
        end else if (!(elems[0] < op.value)) begin
          place(0, op.value);
        end else begin
          place(n, op.value);
        end
      end
      MODE_READ: begin
        if (n == 0) rep.status = ST_EMPTY;
        else if (pos >= n) rep.status = ST_RANGE;
        else rep.read_value = elems[pos];
      end
      default: ;
    endcase
    rep.count = 7'(fill);
    return rep;
  endfunction

  function void note_beat(in_item_t op);
    replies_due.push_back(next_reply(op));
  endfunction

  function void check_reply(out_item_t got);
    out_item_t want;
    if (replies_due.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("unexpected reply: status %0d count %0d read_value %0d",
                 got.status, got.count, got.read_value);
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status || got.count !== want.count ||
        got.read_value !== want.read_value) begin
      faults++;
      if (faults <= 10)
        $display("reply differs: status %0d/%0d count %0d/%0d read_value %0d/%0d (exp/got)",
                 want.status, got.status, want.count, got.count,
                 want.read_value, got.read_value);
    end
  endfunction
endclass

module tb_ordered_sequence_store_top;

  // modes the block ignores
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam int RANDOM_BEATS = 1700;

  // traffic mix of one random phase
  typedef enum {GROW, SHRINK, CHURN, PROBE} mix_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // board checks the block; plan is the stimulus side's view of the count
  // and contents, advanced as each beat goes in
  seq_store_scoreboard board = new();
  seq_store_scoreboard plan  = new();
  int                  sent;

  ordered_sequence_store_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor. Everything the block sees or drives changes through
  // nonblocking updates, so the values read here are the ones from just
  // before the edge. The input beat is noted first; with the compare and apply
  // states between accepting a beat and its reply, it can never be the one this edge's reply belongs to.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_beat(in_data);
      if (out_valid && !out_stall) board.check_reply(out_data);
    end
  end

  // Reply-side back-pressure: long free-flowing stretches, short flicker and
  // the odd long hold, so stalls land on every phase of a beat.
  initial begin
    int   r;
    int   hold;
    logic level;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        hold = $urandom_range(30, 150);
        level = 1'b0;
      end else if (r < 60) begin
        hold = $urandom_range(1, 3);
        level = 1'b0;
      end else if (r < 95) begin
        hold = $urandom_range(1, 4);
        level = 1'b1;
      end else begin
        hold = $urandom_range(10, 50);
        level = 1'b1;
      end
      out_stall <= level;
      repeat (hold) @(posedge clk);
    end
  end

  // Idle cycles before a beat: mostly none or short, a few long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DW-1:0] draw_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    // narrow band: plenty of duplicates for the sorted insert
    if (r < 70) return $urandom_range(0, 16) - 8;
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    // just around a stored element, to hit the equal and off-by-one compares
    if (plan.fill > 0)
      return plan.elems[$urandom_range(0, plan.fill - 1)] + $urandom_range(0, 2) - 1;
    return $urandom();
  endfunction

  // Mostly a live index; the rest spans the whole field, out of range included.
  function automatic logic [5:0] draw_pos();
    if (plan.fill > 0 && $urandom_range(0, 99) < 85)
      return 6'($urandom_range(0, plan.fill - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [2:0] any_insert();
    case ($urandom_range(0, 2))
      0: return MODE_INS_BEFORE;
      1: return MODE_INS_AFTER;
      default: return MODE_INS_SORTED;
    endcase
  endfunction

  function automatic logic [2:0] any_op();
    case ($urandom_range(0, 5))
      0: return MODE_INS_BEFORE;
      1: return MODE_INS_AFTER;
      2: return MODE_DEL_AT;
      3: return MODE_DEL_LAST;
      4: return MODE_INS_SORTED;
      default: return MODE_READ;
    endcase
  endfunction

  function automatic in_item_t draw_op(mix_t mix);
    in_item_t op;
    int       r;
    r = $urandom_range(0, 99);
    op = '0;
    if ($urandom_range(0, 99) < 3) begin
      op.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    end else begin
      case (mix)
        GROW:   op.mode = (r < 85) ? any_insert() : any_op();
        SHRINK: op.mode = (r < 45) ? MODE_DEL_AT : (r < 80) ? MODE_DEL_LAST : any_op();
        PROBE:  op.mode = (r < 60) ? MODE_READ : any_op();
        default: op.mode = any_op();
      endcase
    end
    op.value = draw_value();
    op.position = draw_pos();
    return op;
  endfunction

  function automatic in_item_t mk(logic [2:0] mode, logic signed [DW-1:0] value,
                                  logic [5:0] position);
    in_item_t op;
    op.mode = mode;
    op.value = value;
    op.position = position;
    return op;
  endfunction

  // Holds the beat until accepted. Valid is lowered only when a gap follows,
  // so back-to-back beats keep it high with a single update per edge.
  task automatic send_beat(in_item_t op, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(in_item_t op, bit burst);
    send_beat(op, burst ? 0 : draw_gap());
    void'(plan.next_reply(op));
    if (op.mode <= MODE_READ) sent++;
  endtask

  initial begin
    mix_t mix;
    bit   burst;
    int   extra;
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // empty store: every read and delete is refused
    issue(mk(MODE_READ,     0, 0), 0);
    issue(mk(MODE_DEL_AT,   0, 0), 0);
    issue(mk(MODE_DEL_LAST, 0, 0), 0);
    // insert into empty ignores the position
    issue(mk(MODE_INS_AFTER,  100, 63), 0);
    issue(mk(MODE_INS_BEFORE,   7,  1), 0);
    issue(mk(MODE_INS_AFTER,    7, 63), 0);
    // sorted insert: head, tail, duplicate in the middle, equal to head and tail
    issue(mk(MODE_INS_SORTED, 32'sh8000_0000, 0), 0);
    issue(mk(MODE_INS_SORTED, 32'sh7fff_ffff, 0), 0);
    issue(mk(MODE_INS_SORTED, 100, 0), 0);
    issue(mk(MODE_INS_SORTED, 32'sh8000_0000, 0), 0);
    issue(mk(MODE_INS_SORTED, 32'sh7fff_ffff, 0), 0);
    // positional inserts leave it unsorted; sorted insert then appends
    issue(mk(MODE_INS_BEFORE, -1, 0), 0);
    issue(mk(MODE_INS_AFTER,   0, 6), 0);
    issue(mk(MODE_INS_SORTED, 50, 0), 0);
    issue(mk(MODE_READ, 0,  0), 0);
    issue(mk(MODE_READ, 0,  8), 0);
    issue(mk(MODE_READ, 0,  9), 0);
    issue(mk(MODE_READ, 0, 63), 0);
    issue(mk(MODE_DEL_AT, 0, 9), 0);
    issue(mk(MODE_DEL_AT, 0, 0), 0);
    issue(mk(MODE_DEL_AT, 0, 7), 0);
    issue(mk(MODE_SPARE_A, 32'sh5a5a_5a5a, 63), 0);
    issue(mk(MODE_SPARE_B, -32'sd1, 0), 0);
    issue(mk(MODE_DEL_LAST, 0, 0), 0);
    issue(mk(MODE_READ, 0, 0), 0);

    // --- random phases ---
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill to the brim, then knock on a full store
          while (plan.fill < DEPTH) issue(draw_op(GROW), burst);
          extra = $urandom_range(1, 4);
          repeat (extra) issue(draw_op(GROW), burst);
        end
        2, 3: begin
          // drain to nothing, then poke the empty store
          while (plan.fill > 0) issue(draw_op(SHRINK), burst);
          extra = $urandom_range(1, 4);
          repeat (extra) issue(draw_op(SHRINK), burst);
        end
        default: begin
          mix = ($urandom_range(0, 2) == 0) ? PROBE : CHURN;
          extra = $urandom_range(20, 100);
          repeat (extra) issue(draw_op(mix), burst);
        end
      endcase
    end
    in_valid <= 1'b0;

    // let the monitor note the last beat, drain outstanding replies, then a
    // short quiet spell to catch strays
    @(posedge clk);
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.faults == 0) begin
      $display("ordered_sequence_store_top: match");
    end else begin
      $display("ordered_sequence_store_top: mismatch");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("ordered_sequence_store_top: mismatch");
    $finish;
  end

endmodule
